FILE: hw/rtl/srts_pkg.sv
// Shared types and constants for the shortest-remaining-time scheduler.
package srts_pkg;

  localparam int TIME_W = 16;
  localparam int ID_W   = 8;
  localparam int SLOT_W = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Result status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;
  localparam logic [1:0] STAT_IDLE = 2'd3;

  // Item mode codes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   process_id;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_time;
  } srts_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              ran;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   served_id;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
  } srts_result_t;

  // One process table entry as held in the table RAM.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
    logic              done;
  } srts_entry_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic scan;
    logic serve;
    logic calc;
    logic emit;
  } srts_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } srts_stat_t;

endpackage

FILE: hw/rtl/srts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/srts_ctrl.sv
// Controller state machine: sequences load, table scan, service and result beat.
module srts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_mode,
  output logic                item_stall,
  input  srts_pkg::srts_stat_t stat,
  output srts_pkg::srts_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_SERVE = 7'b0001000,
    S_CALC  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = (item_mode == srts_pkg::MODE_LOAD) ? S_LOAD : S_SCAN;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_EMIT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_SERVE;
        end
      end
      S_SERVE: begin
        cmd.serve  = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/srts_datapath.sv
// Datapath: process table, scan comparator, time keeping and result register.
module srts_datapath #(
  parameter int MAX_PROCS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  srts_pkg::srts_item_t  item,
  input  srts_pkg::srts_cmd_t   cmd,
  output srts_pkg::srts_stat_t  stat,
  output logic                  result_valid,
  input  logic                  result_stall,
  output srts_pkg::srts_result_t result
);

  localparam int AW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int EW = $bits(srts_pkg::srts_entry_t);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_PROCS);

  srts_pkg::srts_item_t  cur;
  logic [CW-1:0]         count;
  logic [CW-1:0]         done_count;
  logic [srts_pkg::TIME_W-1:0] cur_time;
  logic [srts_pkg::TIME_W-1:0] time_new;

  logic [CW-1:0]         idx;
  logic                  rd_vld;
  logic [AW-1:0]         rd_slot;
  logic                  found;
  logic [AW-1:0]         best_slot;
  srts_pkg::srts_entry_t best;
  srts_pkg::srts_entry_t rd_entry;
  srts_pkg::srts_entry_t wr_entry;
  logic [AW-1:0]         wr_addr;
  logic                  we;
  logic                  fin;

  logic [1:0]                  res_status;
  logic                        res_ran;
  logic [srts_pkg::SLOT_W-1:0] res_slot;
  logic [srts_pkg::ID_W-1:0]   res_id;
  logic                        res_finished;
  logic [srts_pkg::TIME_W-1:0] res_finish;
  logic [srts_pkg::TIME_W-1:0] res_turn;
  logic [srts_pkg::TIME_W-1:0] res_wait;

  logic load_ok;
  logic better;

  assign time_new = (cur_time == srts_pkg::TIME_MAX) ? cur_time : cur_time + 1'b1;
  assign load_ok  = (count != FULL_COUNT) && (cur.burst_time != '0);
  assign fin      = (best.remaining == srts_pkg::TIME_W'(1));
  assign better   = !rd_entry.done && (rd_entry.arrival <= cur_time) &&
                    (!found || (rd_entry.remaining < best.remaining));

  // Write port: new entry on load, updated entry on service.
  always_comb begin
    we       = 1'b0;
    wr_addr  = best_slot;
    wr_entry = best;
    if (cmd.load) begin
      we                 = load_ok;
      wr_addr            = count[AW-1:0];
      wr_entry.id        = cur.process_id;
      wr_entry.arrival   = cur.arrival_time;
      wr_entry.burst     = cur.burst_time;
      wr_entry.remaining = cur.burst_time;
      wr_entry.done      = 1'b0;
    end else if (cmd.serve) begin
      we                 = found;
      wr_entry.remaining = best.remaining - 1'b1;
      wr_entry.done      = fin;
    end
  end

  srts_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (idx[AW-1:0]),
    .rdata (rd_entry)
  );

  assign stat.scan_done = (idx == count) && !rd_vld;
  assign stat.out_busy  = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      done_count <= '0;
      cur_time   <= '0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
      idx        <= '0;
    end else begin
      if (cmd.capture) begin
        idx    <= '0;
        rd_vld <= 1'b0;
        found  <= 1'b0;
      end
      if (cmd.load && load_ok) begin
        count <= count + 1'b1;
      end
      if (cmd.scan) begin
        if (idx < count) begin
          idx    <= idx + 1'b1;
          rd_vld <= 1'b1;
        end else begin
          rd_vld <= 1'b0;
        end
        if (rd_vld && better) begin
          found <= 1'b1;
        end
      end
      if (cmd.serve) begin
        cur_time <= time_new;
        if (found && fin) begin
          done_count <= done_count + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= item;
    end
    if (cmd.scan) begin
      rd_slot <= idx[AW-1:0];
      if (rd_vld && better) begin
        best      <= rd_entry;
        best_slot <= rd_slot;
      end
    end
    if (cmd.load) begin
      res_ran      <= 1'b0;
      res_finished <= 1'b0;
      res_finish   <= '0;
      res_turn     <= '0;
      res_wait     <= '0;
      if (count == FULL_COUNT) begin
        res_status <= srts_pkg::STAT_FULL;
      end else if (cur.burst_time == '0) begin
        res_status <= srts_pkg::STAT_ZERO;
      end else begin
        res_status <= srts_pkg::STAT_OK;
      end
      res_slot <= load_ok ? srts_pkg::SLOT_W'(count) : '0;
      res_id   <= load_ok ? cur.process_id : '0;
    end
    if (cmd.serve) begin
      if (found) begin
        res_status   <= srts_pkg::STAT_OK;
        res_ran      <= 1'b1;
        res_slot     <= srts_pkg::SLOT_W'(best_slot);
        res_id       <= best.id;
        res_finished <= fin;
        res_finish   <= fin ? time_new : '0;
        res_turn     <= fin ? time_new - best.arrival : '0;
      end else begin
        res_status   <= srts_pkg::STAT_IDLE;
        res_ran      <= 1'b0;
        res_slot     <= '0;
        res_id       <= '0;
        res_finished <= 1'b0;
        res_finish   <= '0;
        res_turn     <= '0;
      end
    end
    if (cmd.calc) begin
      res_wait <= (res_finished && (res_turn >= best.burst)) ? res_turn - best.burst : '0;
    end
    if (cmd.emit) begin
      result.status      <= res_status;
      result.ran         <= res_ran;
      result.slot        <= res_slot;
      result.served_id   <= res_id;
      result.finished    <= res_finished;
      result.finish_time <= res_finish;
      result.turnaround  <= res_turn;
      result.waiting     <= res_wait;
      result.all_done    <= (done_count == count);
    end
  end

  // Output register: hold a stalled beat, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/shortest_remaining_time_scheduler_core.sv
// Load item: captured when idle, then the load and emit states put its result beat in the output register.
// Tick item: captured when idle, then the one-entry-a-cycle table scan through the RAM read port,
// at most MAX_PROCS entries, then the serve, calc and emit states build its result beat.
// One item is in work at a time; the next is taken once the previous reaches the output
// register, which holds its beat while the result side stalls.
// Reset clears process count, done count, current time and handshake; the table is kept.
module shortest_remaining_time_scheduler_core #(
  parameter int MAX_PROCS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  srts_pkg::srts_item_t   item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output srts_pkg::srts_result_t result
);

  // Commands from the controller, status back from the datapath.
  srts_pkg::srts_cmd_t  cmd;
  srts_pkg::srts_stat_t stat;

  // Controller: idle, load, scan, serve, calc, emit. Accepts an item only when idle.
  srts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_mode  (item.mode),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: table RAM, minimum-remaining search, completion figures, result beat.
  srts_datapath #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: hw/rtl/srts_checker.sv
// Port-level checks for the scheduler core, bound to the top level.
module srts_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_valid,
  input logic                   item_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input srts_pkg::srts_result_t result
);

  // A stalled result beat stays valid.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // One item at a time: the beat after an accepted item is stalled.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second item accepted while one is in work");

  // Completion only comes with service.
  a_fin_ran: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.finished |-> result.ran && (result.status == srts_pkg::STAT_OK))
    else $error("finish reported without service");

  // An idle tick serves nothing.
  a_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == srts_pkg::STAT_IDLE) |->
      !result.ran && !result.finished && (result.served_id == '0))
    else $error("idle tick reports service");

endmodule

bind shortest_remaining_time_scheduler_core srts_checker u_srts_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
